// ===== rtl/core/ile_pkg.sv =====
// Shared constants, opcodes and controller/datapath command types of the indexed list engine.
package ile_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ELEM_WIDTH_DEF  = 32;

  localparam int OPCODE_W = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic [OPCODE_W-1:0] OP_APPEND   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_GET      = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_SET      = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_POP      = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_INDEX_OF = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL_POP  = 2'd3;

  localparam logic [POS_W-1:0] NO_POSITION = '1;

  typedef logic [2:0] rd_sel_t;
  localparam rd_sel_t RA_ZERO     = 3'd0;
  localparam rd_sel_t RA_POS      = 3'd1;
  localparam rd_sel_t RA_POS_INC  = 3'd2;
  localparam rd_sel_t RA_CNT_DEC  = 3'd3;
  localparam rd_sel_t RA_IDX_INC  = 3'd4;
  localparam rd_sel_t RA_IDX_INC2 = 3'd5;
  localparam rd_sel_t RA_IDX_DEC2 = 3'd6;

  typedef logic [1:0] wa_sel_t;
  localparam wa_sel_t WA_IDX = 2'd0;
  localparam wa_sel_t WA_CNT = 2'd1;
  localparam wa_sel_t WA_POS = 2'd2;

  typedef logic wd_sel_t;
  localparam wd_sel_t WD_ELEM = 1'b0;
  localparam wd_sel_t WD_RDQ  = 1'b1;

  typedef logic [1:0] ix_sel_t;
  localparam ix_sel_t IX_ZERO = 2'd0;
  localparam ix_sel_t IX_CNT  = 2'd1;
  localparam ix_sel_t IX_POS  = 2'd2;

  typedef struct packed {
    logic                capture;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wa_sel_t             wa_sel;
    wd_sel_t             wd_sel;
    logic                idx_load;
    ix_sel_t             idx_sel;
    logic                idx_inc;
    logic                idx_dec;
    logic                count_inc;
    logic                count_dec;
    logic                count_clr;
    logic                set_status;
    logic [STATUS_W-1:0] status_val;
    logic                set_rdata;
    logic                set_fpos;
    logic                set_found;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                full;
    logic                in_range;
    logic                pos_le;
    logic                pos_eq;
    logic                down_needed;
    logic                count_zero;
    logic                elem_zero;
    logic                rd_zero;
    logic                match;
    logic                up_last;
    logic                down_last;
    logic                search_last;
    logic                out_free;
  } sts_t;

endpackage

// ===== rtl/core/ile_if.sv =====
// Request and result channel interfaces of the indexed list engine.
interface ile_in_if;
  logic                         valid;
  logic                         ready;
  logic [ile_pkg::OPCODE_W-1:0] opcode;
  logic [ile_pkg::POS_W-1:0]    position;
  logic [ile_pkg::DATA_W-1:0]   element;

  modport source (output valid, output opcode, output position, output element, input ready);
  modport sink (input valid, input opcode, input position, input element, output ready);
endinterface

interface ile_res_if;
  logic                                valid;
  logic                                ready;
  logic [ile_pkg::STATUS_W-1:0]        status;
  logic [ile_pkg::DATA_W-1:0]          read_data;
  logic signed [ile_pkg::POS_W-1:0]    found_position;
  logic                                found;
  logic [ile_pkg::LEN_W-1:0]           length;
  logic                                empty_res;

  modport source (output valid, output status, output read_data, output found_position,
                  output found, output length, output empty_res, input ready);
  modport sink (input valid, input status, input read_data, input found_position,
                input found, input length, input empty_res, output ready);
endinterface

// ===== rtl/core/ile_datapath.sv =====
// Datapath of the indexed list engine: entry memory, count, walk index and result registers.
module ile_datapath #(
  parameter int MAX_ENTRIES = ile_pkg::MAX_ENTRIES_DEF,
  parameter int ELEM_WIDTH  = ile_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ile_pkg::OPCODE_W-1:0] opcode,
  input  logic [ile_pkg::POS_W-1:0]    position,
  input  logic [ile_pkg::DATA_W-1:0]   element,
  input  ile_pkg::cmd_t                cmd,
  output ile_pkg::sts_t                sts,
  ile_res_if.source                    res_ch
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = (CW > ile_pkg::POS_W) ? CW + 1 : ile_pkg::POS_W + 1;

  logic [ELEM_WIDTH-1:0]          mem [MAX_ENTRIES];
  logic [ELEM_WIDTH-1:0]          rd_q;
  logic [ile_pkg::OPCODE_W-1:0]   op_q;
  logic [ile_pkg::POS_W-1:0]      pos_q;
  logic [ELEM_WIDTH-1:0]          elem_q;
  logic [CW-1:0]                  count;
  logic [AW-1:0]                  idx;
  logic [ile_pkg::STATUS_W-1:0]   status_q;
  logic [ELEM_WIDTH-1:0]          rdata_q;
  logic [ile_pkg::POS_W-1:0]      fpos_q;
  logic                           found_q;
  logic                           out_valid;
  logic [ile_pkg::STATUS_W-1:0]   out_status;
  logic [ile_pkg::DATA_W-1:0]     out_rdata;
  logic [ile_pkg::POS_W-1:0]      out_fpos;
  logic                           out_found;
  logic [ile_pkg::LEN_W-1:0]      out_length;
  logic                           out_empty;

  logic [AW-1:0]         pos_a;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         idx_x;

  assign pos_a = AW'(pos_q);
  assign cnt_x = XW'(count);
  assign pos_x = XW'(pos_q);
  assign idx_x = XW'(idx);

  always_comb begin
    case (cmd.rd_sel)
      ile_pkg::RA_ZERO:     rd_addr = '0;
      ile_pkg::RA_POS:      rd_addr = pos_a;
      ile_pkg::RA_POS_INC:  rd_addr = pos_a + AW'(1);
      ile_pkg::RA_CNT_DEC:  rd_addr = AW'(count - CW'(1));
      ile_pkg::RA_IDX_INC:  rd_addr = idx + AW'(1);
      ile_pkg::RA_IDX_INC2: rd_addr = idx + AW'(2);
      ile_pkg::RA_IDX_DEC2: rd_addr = idx - AW'(2);
      default:              rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      ile_pkg::WA_CNT: wr_addr = AW'(count);
      ile_pkg::WA_POS: wr_addr = pos_a;
      default:         wr_addr = idx;
    endcase
  end

  assign wr_data = (cmd.wd_sel == ile_pkg::WD_RDQ) ? rd_q : elem_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      pos_q  <= position;
      elem_q <= ELEM_WIDTH'(element);
    end
    if (cmd.idx_load) begin
      case (cmd.idx_sel)
        ile_pkg::IX_CNT: idx <= AW'(count);
        ile_pkg::IX_POS: idx <= pos_a;
        default:         idx <= '0;
      endcase
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end
    if (cmd.capture) begin
      status_q <= ile_pkg::ST_OK;
      rdata_q  <= '0;
      fpos_q   <= ile_pkg::NO_POSITION;
      found_q  <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_q <= cmd.status_val;
      end
      if (cmd.set_rdata) begin
        rdata_q <= rd_q;
      end
      if (cmd.set_fpos) begin
        fpos_q <= ile_pkg::POS_W'(idx);
      end
      if (cmd.set_found) begin
        found_q <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_status <= status_q;
      out_rdata  <= ile_pkg::DATA_W'(rdata_q);
      out_fpos   <= fpos_q;
      out_found  <= found_q;
      out_length <= ile_pkg::LEN_W'(count);
      out_empty  <= (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op          = op_q;
    sts.full        = (count == CW'(MAX_ENTRIES));
    sts.in_range    = (pos_x < cnt_x);
    sts.pos_le      = (pos_x <= cnt_x);
    sts.pos_eq      = (pos_x == cnt_x);
    sts.down_needed = ((pos_x + XW'(1)) < cnt_x);
    sts.count_zero  = (count == '0);
    sts.elem_zero   = (elem_q == '0);
    sts.rd_zero     = (rd_q == '0);
    sts.match       = (rd_q == elem_q);
    sts.up_last     = (idx_x == (pos_x + XW'(1)));
    sts.down_last   = ((idx_x + XW'(2)) == cnt_x);
    sts.search_last = ((idx_x + XW'(1)) == cnt_x);
    sts.out_free    = !out_valid || res_ch.ready;
  end

  assign res_ch.valid          = out_valid;
  assign res_ch.status         = out_status;
  assign res_ch.read_data      = out_rdata;
  assign res_ch.found_position = out_fpos;
  assign res_ch.found          = out_found;
  assign res_ch.length         = out_length;
  assign res_ch.empty_res      = out_empty;

endmodule

// ===== rtl/core/ile_controller.sv =====
// Controller state machine of the indexed list engine: sequences decode, shifts and searches.
module ile_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ile_pkg::sts_t sts,
  output ile_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_SHIFT_UP   = 4'd2;
  localparam logic [3:0] S_INS_FILL   = 4'd3;
  localparam logic [3:0] S_SHIFT_DOWN = 4'd4;
  localparam logic [3:0] S_POP_CHECK  = 4'd5;
  localparam logic [3:0] S_GET_WAIT   = 4'd6;
  localparam logic [3:0] S_SEARCH     = 4'd7;
  localparam logic [3:0] S_RESULT     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESULT;
        case (sts.op)
          ile_pkg::OP_APPEND: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_FULL;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wa_sel    = ile_pkg::WA_CNT;
              cmd.wd_sel    = ile_pkg::WD_ELEM;
              cmd.count_inc = 1'b1;
            end
          end
          ile_pkg::OP_INSERT: begin
            if (!sts.pos_le) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_BAD_INDEX;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_FULL;
            end else if (sts.pos_eq) begin
              cmd.wr_en     = 1'b1;
              cmd.wa_sel    = ile_pkg::WA_POS;
              cmd.wd_sel    = ile_pkg::WD_ELEM;
              cmd.count_inc = 1'b1;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ile_pkg::RA_CNT_DEC;
              cmd.idx_load = 1'b1;
              cmd.idx_sel  = ile_pkg::IX_CNT;
              state_next   = S_SHIFT_UP;
            end
          end
          ile_pkg::OP_GET: begin
            if (!sts.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_BAD_INDEX;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ile_pkg::RA_POS;
              state_next = S_GET_WAIT;
            end
          end
          ile_pkg::OP_SET: begin
            if (!sts.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_BAD_INDEX;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = ile_pkg::WA_POS;
              cmd.wd_sel = ile_pkg::WD_ELEM;
            end
          end
          ile_pkg::OP_REMOVE: begin
            if (!sts.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_BAD_INDEX;
            end else if (sts.down_needed) begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ile_pkg::RA_POS_INC;
              cmd.idx_load = 1'b1;
              cmd.idx_sel  = ile_pkg::IX_POS;
              state_next   = S_SHIFT_DOWN;
            end else begin
              cmd.count_dec = 1'b1;
            end
          end
          ile_pkg::OP_POP: begin
            if (!sts.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ile_pkg::ST_BAD_INDEX;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ile_pkg::RA_POS;
              state_next = S_POP_CHECK;
            end
          end
          ile_pkg::OP_INDEX_OF: begin
            if (!sts.count_zero) begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ile_pkg::RA_ZERO;
              cmd.idx_load = 1'b1;
              cmd.idx_sel  = ile_pkg::IX_ZERO;
              state_next   = S_SEARCH;
            end
          end
          ile_pkg::OP_CONTAINS: begin
            if (!sts.count_zero && !sts.elem_zero) begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ile_pkg::RA_ZERO;
              cmd.idx_load = 1'b1;
              cmd.idx_sel  = ile_pkg::IX_ZERO;
              state_next   = S_SEARCH;
            end
          end
          ile_pkg::OP_CLEAR: begin
            cmd.count_clr = 1'b1;
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ile_pkg::WA_IDX;
        cmd.wd_sel = ile_pkg::WD_RDQ;
        if (sts.up_last) begin
          state_next = S_INS_FILL;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = ile_pkg::RA_IDX_DEC2;
          cmd.idx_dec = 1'b1;
        end
      end
      S_INS_FILL: begin
        cmd.wr_en     = 1'b1;
        cmd.wa_sel    = ile_pkg::WA_POS;
        cmd.wd_sel    = ile_pkg::WD_ELEM;
        cmd.count_inc = 1'b1;
        state_next    = S_RESULT;
      end
      S_SHIFT_DOWN: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ile_pkg::WA_IDX;
        cmd.wd_sel = ile_pkg::WD_RDQ;
        if (sts.down_last) begin
          cmd.count_dec = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = ile_pkg::RA_IDX_INC2;
          cmd.idx_inc = 1'b1;
        end
      end
      S_POP_CHECK: begin
        if (sts.rd_zero) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ile_pkg::ST_NULL_POP;
          state_next     = S_RESULT;
        end else begin
          cmd.set_rdata = 1'b1;
          if (sts.down_needed) begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = ile_pkg::RA_POS_INC;
            cmd.idx_load = 1'b1;
            cmd.idx_sel  = ile_pkg::IX_POS;
            state_next   = S_SHIFT_DOWN;
          end else begin
            cmd.count_dec = 1'b1;
            state_next    = S_RESULT;
          end
        end
      end
      S_GET_WAIT: begin
        cmd.set_rdata = 1'b1;
        state_next    = S_RESULT;
      end
      S_SEARCH: begin
        if (sts.match) begin
          if (sts.op == ile_pkg::OP_INDEX_OF) begin
            cmd.set_fpos = 1'b1;
          end else begin
            cmd.set_found = 1'b1;
          end
          state_next = S_RESULT;
        end else if (sts.search_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = ile_pkg::RA_IDX_INC;
          cmd.idx_inc = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Top level of the indexed list engine: controller, datapath and channel hookup.
// The engine keeps an ordered list of up to MAX_ENTRIES words in a one-read, one-write
// memory and handles one transaction at a time, returning one result transaction each.
// Append, set, clear, unused opcodes, out-of-range requests, insert at the end and remove
// of the last entry finish in the decode state; get adds one read-wait state.
// Insert and remove walk the memory one entry per cycle, shifting the entries between the
// position and the count; pop first checks the entry read for zero. Index_of and contains
// read one entry per cycle from the front and stop at the first match or the last entry.
// A result that still waits unaccepted in the output register stalls the next transaction
// in the result state. The list is empty after reset with no clearing pass; entries at or
// above the count are never read. A finished result waits in an output register, and the
// next transaction is accepted meanwhile.
module indexed_list_engine #(
  parameter int MAX_ENTRIES = ile_pkg::MAX_ENTRIES_DEF,
  parameter int ELEM_WIDTH  = ile_pkg::ELEM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ile_in_if.sink     in_ch,
  ile_res_if.source  res_ch
);

  ile_pkg::cmd_t cmd;
  ile_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  ile_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ile_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .opcode   (in_ch.opcode),
    .position (in_ch.position),
    .element  (in_ch.element),
    .cmd      (cmd),
    .sts      (sts),
    .res_ch   (res_ch)
  );

endmodule

// ===== bench/tb_indexed_list_engine.sv =====
// Self-checking testbench of the indexed list engine with its own list predictor.
module tb_indexed_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int LIST_DEPTH   = MAX_ENTRIES_DEF;
  localparam int ITEM_TARGET  = 1900;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 40;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = OP_CLEAR + OPCODE_W'(1);
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = '1;

  typedef enum int {PH_MIXED, PH_FILL, PH_SHRINK, PH_SEARCH} phase_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [POS_W-1:0]    found_position;
    logic                found;
    logic [LEN_W-1:0]    length;
    logic                empty_res;
  } list_result_t;

  class list_scoreboard;
    logic [DATA_W-1:0] entries [LIST_DEPTH];
    int count;
    int peak_count;
    int mismatches;
    int results_checked;
    int status_seen [4];
    int op_seen [16];
    list_result_t awaited_results [$];

    function new();
      count = 0;
      peak_count = 0;
      mismatches = 0;
      results_checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function void predict_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                  logic [DATA_W-1:0] elem);
      list_result_t r;
      int i;
      int p;
      bit hit;
      r = '{status: ST_OK, read_data: '0, found_position: NO_POSITION, found: 1'b0,
            length: '0, empty_res: 1'b0};
      p = int'(pos);
      hit = 0;
      case (op)
        OP_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            entries[count] = elem;
            count++;
          end
        end
        OP_INSERT: begin
          if (p > count) begin
            r.status = ST_BAD_INDEX;
          end else if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > p; i--) entries[i] = entries[i-1];
            entries[p] = elem;
            count++;
          end
        end
        OP_GET: begin
          if (p >= count) r.status = ST_BAD_INDEX;
          else r.read_data = entries[p];
        end
        OP_SET: begin
          if (p >= count) r.status = ST_BAD_INDEX;
          else entries[p] = elem;
        end
        OP_REMOVE: begin
          if (p >= count) begin
            r.status = ST_BAD_INDEX;
          end else begin
            for (i = p; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        OP_POP: begin
          if (p >= count) begin
            r.status = ST_BAD_INDEX;
          end else if (entries[p] == '0) begin
            r.status = ST_NULL_POP;
          end else begin
            r.read_data = entries[p];
            for (i = p; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        OP_INDEX_OF: begin
          for (i = 0; i < count; i++) begin
            if (!hit && entries[i] == elem) begin
              r.found_position = POS_W'(i);
              hit = 1;
            end
          end
        end
        OP_CONTAINS: begin
          if (elem != '0) begin
            for (i = 0; i < count; i++) begin
              if (entries[i] == elem) r.found = 1'b1;
            end
          end
        end
        OP_CLEAR: count = 0;
        default: ;
      endcase
      r.length = LEN_W'(count);
      r.empty_res = (count == 0);
      if (count > peak_count) peak_count = count;
      op_seen[op]++;
      status_seen[r.status]++;
      awaited_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("MISMATCH at %0t ns, result %0d: %s got 0x%0h, expected 0x%0h",
                 $time, results_checked, what, got, want);
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no transaction waiting, length", got.length, '0);
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.found_position !== want.found_position)
        report_mismatch("found_position", got.found_position, want.found_position);
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.length !== want.length) report_mismatch("length", got.length, want.length);
      if (got.empty_res !== want.empty_res)
        report_mismatch("empty_res", got.empty_res, want.empty_res);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ile_in_if  req_ch ();
  ile_res_if res_ch ();

  indexed_list_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .res_ch (res_ch)
  );

  list_scoreboard board;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 0;
  int rx_mode = 0;
  int rx_tick = 0;
  int hold_left = 0;
  bit hold_request = 0;

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_APPEND;
    req_ch.position = '0;
    req_ch.element = '0;
    res_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               board.awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    list_result_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        board.predict_request(req_ch.opcode, req_ch.position, req_ch.element);
      if (res_ch.valid && res_ch.ready) begin
        got.status = res_ch.status;
        got.read_data = res_ch.read_data;
        got.found_position = res_ch.found_position;
        got.found = res_ch.found;
        got.length = res_ch.length;
        got.empty_res = res_ch.empty_res;
        board.check_result(got);
      end
    end
  end

  // The receiver follows its own stall pattern, and a long hold-off once requested.
  always @(negedge clk) begin
    rx_tick++;
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        0: res_ch.ready = 1'b1;
        1: res_ch.ready = ($urandom_range(0, 9) < 7);
        2: res_ch.ready = ((rx_tick % 7) >= 3);
        default: res_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] elem);
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.position = pos;
    req_ch.element = elem;
    items_sent++;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    req_ch.valid = 1'b0;
    repeat (cycles) begin
      req_ch.opcode = OPCODE_W'($urandom_range(0, 15));
      req_ch.position = POS_W'($urandom_range(0, 127));
      req_ch.element = $urandom();
      @(negedge clk);
    end
  endtask

  task automatic wait_until_drained();
    req_ch.valid = 1'b0;
    while (board.awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic paced_send(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                            logic [DATA_W-1:0] elem);
    if (burst_left == 0) begin
      if (gaps_on) idle_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(op, pos, elem);
  endtask

  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return 32'hA5A5_0000 ^ DATA_W'($urandom_range(0, 7));
      4: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      5, 6: begin
        if (board.count > 0) return board.entries[$urandom_range(0, board.count - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    int c;
    r = $urandom_range(0, 19);
    c = board.count;
    if (r < 15) return POS_W'($urandom_range(0, c));
    if (r < 18) return POS_W'((c + $urandom_range(0, 2) > 127) ? 127 : c + $urandom_range(0, 2));
    return POS_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode(phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_SHRINK: begin
        if (r < 35) return OP_REMOVE;
        if (r < 70) return OP_POP;
        if (r < 80) return OP_GET;
        if (r < 90) return OP_APPEND;
        return OP_INDEX_OF;
      end
      PH_SEARCH: begin
        if (r < 40) return OP_INDEX_OF;
        if (r < 80) return OP_CONTAINS;
        if (r < 90) return OP_SET;
        return OP_APPEND;
      end
      default: begin
        if (r < 16) return OP_APPEND;
        if (r < 32) return OP_INSERT;
        if (r < 44) return OP_GET;
        if (r < 54) return OP_SET;
        if (r < 64) return OP_REMOVE;
        if (r < 74) return OP_POP;
        if (r < 84) return OP_INDEX_OF;
        if (r < 94) return OP_CONTAINS;
        if (r < 97) return OP_CLEAR;
        return OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
    endcase
  endfunction

  // Fills the list to the top, then works the full-list and longest-walk cases.
  task automatic fill_phase();
    while (board.count < LIST_DEPTH) paced_send(OP_APPEND, pick_position(), pick_element());
    paced_send(OP_APPEND, '0, pick_element());
    paced_send(OP_INSERT, '0, pick_element());
    paced_send(OP_INSERT, POS_W'(LIST_DEPTH), pick_element());
    paced_send(OP_INSERT, POS_W'($urandom_range(LIST_DEPTH + 1, 127)), pick_element());
    paced_send(OP_INDEX_OF, '0, board.entries[LIST_DEPTH - 1]);
    paced_send(OP_CONTAINS, '0, $urandom());
    paced_send(OP_REMOVE, '0, '0);
    paced_send(OP_INSERT, '0, pick_element());
    paced_send(OP_POP, POS_W'($urandom_range(0, LIST_DEPTH - 1)), '0);
  endtask

  task automatic run_random_part(int target);
    int phase_no;
    int phase_len;
    int k;
    phase_kind_t kind;
    logic [OPCODE_W-1:0] op;
    phase_no = 0;
    while (items_sent < target) begin
      kind = phase_kind_t'($urandom_range(0, 3));
      rx_mode = $urandom_range(0, 3);
      gaps_on = $urandom_range(0, 2) != 0;
      burst_left = 0;
      if (phase_no % 6 == 2) begin
        gaps_on = 0;
        hold_request = 1;
      end
      if (kind == PH_FILL) begin
        fill_phase();
      end else begin
        phase_len = $urandom_range(40, 120);
        for (k = 0; k < phase_len && items_sent < target; k++) begin
          op = pick_opcode(kind);
          paced_send(op, pick_position(), pick_element());
        end
      end
      if (phase_no % 5 == 4) wait_until_drained();
      phase_no++;
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    rx_mode = 0;

    send_item(OP_GET, '0, '0);
    send_item(OP_POP, '0, '0);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_INDEX_OF, '0, '0);
    send_item(OP_INSERT, 7'd1, 32'h0000_0001);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, '1, '1);
    send_item(OP_INSERT, '0, 32'h8000_0001);
    send_item(OP_INSERT, 7'd3, 32'h5A5A_A5A5);
    send_item(OP_INSERT, 7'd5, 32'h0000_0001);
    send_item(OP_GET, '1, '0);
    send_item(OP_GET, 7'd3, '0);
    send_item(OP_SET, 7'd4, 32'h0000_0001);
    send_item(OP_SET, 7'd3, 32'h7FFF_FFFF);
    send_item(OP_POP, 7'd1, '0);
    send_item(OP_INDEX_OF, '0, '0);
    send_item(OP_CONTAINS, '0, '0);
    send_item(OP_CONTAINS, '0, '1);
    send_item(OP_INDEX_OF, '0, 32'h1234_5678);
    send_item(OP_POP, '0, '0);
    send_item(OP_REMOVE, 7'd2, '0);
    send_item(OP_UNUSED_FIRST, '1, '1);
    send_item(OP_UNUSED_LAST, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    wait_until_drained();

    run_random_part(items_sent + ITEM_TARGET);

    wait_until_drained();
    idle_sender(SETTLE_CYCLES);

    $display("Run covered %0d transactions in %0d cycles, peak list length %0d of %0d.",
             board.results_checked, cycle_count, board.peak_count, LIST_DEPTH);
    $display("Statuses seen: ok %0d, bad index %0d, full %0d, null pop %0d; clears %0d.",
             board.status_seen[ST_OK], board.status_seen[ST_BAD_INDEX],
             board.status_seen[ST_FULL], board.status_seen[ST_NULL_POP],
             board.op_seen[OP_CLEAR]);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_datapath.sv
rtl/core/ile_controller.sv
rtl/core/indexed_list_engine.sv
bench/tb_indexed_list_engine.sv
